/* src/color_threshold_bounding_box_unit_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the colour-threshold bounding box unit
// Shared concurrent assertion forms, clocked; all but CTBB_ASSERT_ALWAYS are held off during reset.
// ---------------------------------------------------------------------------
`ifndef COLOR_THRESHOLD_BOUNDING_BOX_UNIT_MACROS_SVH
`define COLOR_THRESHOLD_BOUNDING_BOX_UNIT_MACROS_SVH

// same-cycle implication
`define CTBB_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CTBB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// implication that is also checked while reset is held
`define CTBB_ASSERT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* src/ctbb_pkg.sv */
// ---------------------------------------------------------------------------
// ctbb_pkg
// Types, constants and helpers shared by the bounding box unit.
// ---------------------------------------------------------------------------
`default_nettype none

package ctbb_pkg;

    localparam int MAX_DIM   = 4096;
    localparam int DIM_W     = $clog2(MAX_DIM + 1);  // holds MAX_DIM itself
    localparam int CNT_W     = $clog2(MAX_DIM);      // column / row index
    localparam int CFG_DIM_W = 13;                   // register field width
    localparam int OUT_W     = 13;                   // box port width
    localparam int CH_W      = 8;

    // queue between front and back, power of two
    localparam int QDEPTH = 2;

    // register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_MIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_MAX    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RED_MAX      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd4;

    localparam logic [CH_W-1:0]      RST_BLUE_MIN     = 8'd205;
    localparam logic [CH_W-1:0]      RST_GREEN_MAX    = 8'd190;
    localparam logic [CH_W-1:0]      RST_RED_MAX      = 8'd150;
    localparam logic [CFG_DIM_W-1:0] RST_FRAME_WIDTH  = 13'd640;
    localparam logic [CFG_DIM_W-1:0] RST_FRAME_HEIGHT = 13'd480;

    typedef struct packed {
        logic [CH_W-1:0]  blue_min;
        logic [CH_W-1:0]  green_max;
        logic [CH_W-1:0]  red_max;
        logic [DIM_W-1:0] width;    // effective, 1..MAX_DIM
        logic [DIM_W-1:0] height;
    } t_cfg;

    // one classified pixel
    typedef struct packed {
        logic             hit;
        logic [CNT_W-1:0] row;
        logic [CNT_W-1:0] col;
        logic             last;     // final pixel of the frame
    } t_px;

    typedef struct packed {
        logic             found;
        logic [OUT_W-1:0] top;
        logic [OUT_W-1:0] left;
        logic [OUT_W-1:0] bottom;
        logic [OUT_W-1:0] right;
    } t_res;

    // zero acts as one, oversize clamps to MAX_DIM
    function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (32'(v) > MAX_DIM) begin
            r = DIM_W'(MAX_DIM);
        end else begin
            r = DIM_W'(v);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* src/color_threshold_bounding_box_unit.sv */
// ---------------------------------------------------------------------------
// color_threshold_bounding_box_unit
// Colour-threshold bounding box over a raster-order pixel stream.
// ---------------------------------------------------------------------------
//
//  Channel   Handshake               Payload
//  --------  ----------------------  ------------------------------------------
//  pixel in  i_push / o_full         i_chan_blue, i_chan_green, i_chan_red
//  result    o_empty / i_pop         o_found, o_box_top/left/bottom/right
//  config    i_cfg_we (no stall)     i_cfg_idx, i_cfg_wdata
//
//  One pixel beat per cycle sustained while o_full stays low; a pixel
//  reaches the back end through the registers of the two-entry queue, and
//  its frame result is registered in the result slot. The back end stalls
//  only on the final pixel of a frame while the previous result still sits unpopped.
//  Reset is synchronous, active low; it clears counters, queue and
//  result valid and restores the register defaults. No clearing pass.
//
// ---------------------------------------------------------------------------
`default_nettype none

module color_threshold_bounding_box_unit
    import ctbb_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // pixel stream
    input  wire logic                 i_push,
    output logic                      o_full,
    input  wire logic [CH_W-1:0]      i_chan_blue,
    input  wire logic [CH_W-1:0]      i_chan_green,
    input  wire logic [CH_W-1:0]      i_chan_red,
    // register writes
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_DIM_W-1:0] i_cfg_wdata,
    // frame results
    output logic                      o_empty,
    input  wire logic                 i_pop,
    output logic                      o_found,
    output logic [OUT_W-1:0]          o_box_top,
    output logic [OUT_W-1:0]          o_box_left,
    output logic [OUT_W-1:0]          o_box_bottom,
    output logic [OUT_W-1:0]          o_box_right
);

    // -- registers -----------------------------------------------------------
    logic [CH_W-1:0]      r_blue_min;
    logic [CH_W-1:0]      r_green_max;
    logic [CH_W-1:0]      r_red_max;
    logic [CFG_DIM_W-1:0] r_frame_width;
    logic [CFG_DIM_W-1:0] r_frame_height;
    t_cfg                 cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blue_min     <= RST_BLUE_MIN;
            r_green_max    <= RST_GREEN_MAX;
            r_red_max      <= RST_RED_MAX;
            r_frame_width  <= RST_FRAME_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_BLUE_MIN:     r_blue_min     <= i_cfg_wdata[CH_W-1:0];
                REG_GREEN_MAX:    r_green_max    <= i_cfg_wdata[CH_W-1:0];
                REG_RED_MAX:      r_red_max      <= i_cfg_wdata[CH_W-1:0];
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_wdata;
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg_wdata;
                default: begin
                    // unmapped index: write dropped
                end
            endcase
        end
    end

    // dimensions clamped once here; both halves see the effective size
    always_comb begin
        cfg.blue_min  = r_blue_min;
        cfg.green_max = r_green_max;
        cfg.red_max   = r_red_max;
        cfg.width     = eff_dim(r_frame_width);
        cfg.height    = eff_dim(r_frame_height);
    end

    // -- front: classify and position ----------------------------------------
    logic q_full, q_empty, q_wr, q_rd;
    t_px  q_wr_data, q_rd_data;

    assign o_full = q_full;

    ctbb_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_push       (i_push),
        .i_chan_blue  (i_chan_blue),
        .i_chan_green (i_chan_green),
        .i_chan_red   (i_chan_red),
        .i_q_full     (q_full),
        .o_wr_en      (q_wr),
        .o_wr_data    (q_wr_data)
    );

    // -- decoupling queue ------------------------------------------------------
    ctbb_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (q_wr),
        .i_wr_data (q_wr_data),
        .i_rd_en   (q_rd),
        .o_rd_data (q_rd_data),
        .o_full    (q_full),
        .o_empty   (q_empty)
    );

    // -- back: box update and result slot --------------------------------------
    t_res res;

    ctbb_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_px      (q_rd_data),
        .i_q_empty (q_empty),
        .o_q_rd    (q_rd),
        .i_pop     (i_pop),
        .o_empty   (o_empty),
        .o_res     (res)
    );

    assign o_found      = res.found;
    assign o_box_top    = res.top;
    assign o_box_left   = res.left;
    assign o_box_bottom = res.bottom;
    assign o_box_right  = res.right;

endmodule

`default_nettype wire

/* src/ctbb_front.sv */
// ---------------------------------------------------------------------------
// ctbb_front
// Pixel intake: threshold test and raster position counters.
// ---------------------------------------------------------------------------
`default_nettype none

module ctbb_front
    import ctbb_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire t_cfg            i_cfg,
    input  wire logic            i_push,
    input  wire logic [CH_W-1:0] i_chan_blue,
    input  wire logic [CH_W-1:0] i_chan_green,
    input  wire logic [CH_W-1:0] i_chan_red,
    input  wire logic            i_q_full,
    output logic                 o_wr_en,
    output t_px                  o_wr_data
);

    logic [CNT_W-1:0] r_col, n_col;
    logic [CNT_W-1:0] r_row, n_row;
    logic             row_end;
    logic             frame_end;

    assign o_wr_en   = i_push && !i_q_full;

    // >= so a shrink mid-frame still closes the row at the next beat
    assign row_end   = (DIM_W'(r_col) + DIM_W'(1)) >= i_cfg.width;
    assign frame_end = row_end && ((DIM_W'(r_row) + DIM_W'(1)) >= i_cfg.height);

    always_comb begin
        o_wr_data.hit  = (i_chan_blue > i_cfg.blue_min) &&
                         (i_chan_green < i_cfg.green_max) &&
                         (i_chan_red < i_cfg.red_max);
        o_wr_data.row  = r_row;
        o_wr_data.col  = r_col;
        o_wr_data.last = frame_end;
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (o_wr_en) begin
            if (row_end) begin
                n_col = '0;
                n_row = frame_end ? '0 : r_row + CNT_W'(1);
            end else begin
                n_col = r_col + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

`default_nettype wire

/* src/ctbb_queue.sv */
// ---------------------------------------------------------------------------
// ctbb_queue
// Short register queue of classified pixels between front and back.
// ---------------------------------------------------------------------------
`default_nettype none

module ctbb_queue
    import ctbb_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_wr_en,
    input  wire t_px  i_wr_data,
    input  wire logic i_rd_en,
    output t_px       o_rd_data,
    output logic      o_full,
    output logic      o_empty
);

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_QW = $clog2(QDEPTH + 1);

    t_px               r_mem [QDEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CNT_QW-1:0] r_count, n_count;
    logic              do_wr, do_rd;

    assign o_full    = (r_count == CNT_QW'(QDEPTH));
    assign o_empty   = (r_count == '0);
    assign do_wr     = i_wr_en && !o_full;
    assign do_rd     = i_rd_en && !o_empty;
    assign o_rd_data = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (do_wr && !do_rd) begin
            n_count = r_count + CNT_QW'(1);
        end else if (do_rd && !do_wr) begin
            n_count = r_count - CNT_QW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (do_wr) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (do_rd) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

/* src/ctbb_back.sv */
// ---------------------------------------------------------------------------
// ctbb_back
// Box accumulation and per-frame result register.
// ---------------------------------------------------------------------------
`default_nettype none

module ctbb_back
    import ctbb_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cfg i_cfg,
    input  wire t_px  i_px,
    input  wire logic i_q_empty,
    output logic      o_q_rd,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_res      o_res
);

    logic             r_any, n_any;
    logic [CNT_W-1:0] r_min_row, n_min_row;
    logic [CNT_W-1:0] r_min_col, n_min_col;
    logic [CNT_W-1:0] r_max_row, n_max_row;
    logic [CNT_W-1:0] r_max_col, n_max_col;
    logic             r_out_valid, n_out_valid;
    t_res             r_res, n_res;
    logic             out_ready;

    // result slot frees up in the same cycle it is popped
    assign out_ready = !r_out_valid || i_pop;
    assign o_q_rd    = !i_q_empty && (!i_px.last || out_ready);
    assign o_empty   = !r_out_valid;
    assign o_res     = r_res;

    always_comb begin
        n_any     = r_any;
        n_min_row = r_min_row;
        n_min_col = r_min_col;
        n_max_row = r_max_row;
        n_max_col = r_max_col;
        if (o_q_rd && i_px.hit) begin
            // first hit loads all four directly
            if (!r_any || i_px.row < r_min_row) n_min_row = i_px.row;
            if (!r_any || i_px.col < r_min_col) n_min_col = i_px.col;
            if (!r_any || i_px.row > r_max_row) n_max_row = i_px.row;
            if (!r_any || i_px.col > r_max_col) n_max_col = i_px.col;
            n_any = 1'b1;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid && !i_pop;
        n_res       = r_res;
        if (o_q_rd && i_px.last) begin
            n_out_valid = 1'b1;
            if (n_any) begin
                n_res.found  = 1'b1;
                n_res.top    = OUT_W'(n_min_row);
                n_res.left   = OUT_W'(n_min_col);
                n_res.bottom = OUT_W'(n_max_row);
                n_res.right  = OUT_W'(n_max_col);
            end else begin
                n_res.found  = 1'b0;
                n_res.top    = '0;
                n_res.left   = '0;
                n_res.bottom = OUT_W'(i_cfg.height);
                n_res.right  = OUT_W'(i_cfg.width);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_min_row <= n_min_row;
        r_min_col <= n_min_col;
        r_max_row <= n_max_row;
        r_max_col <= n_max_col;
        r_res     <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_any       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // end of frame starts the next box afresh
            r_any       <= (o_q_rd && i_px.last) ? 1'b0 : n_any;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

/* src/ctbb_checker.sv */
// ---------------------------------------------------------------------------
// ctbb_checker
// Port-level checks on the bounding box unit, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "color_threshold_bounding_box_unit_macros.svh"

module ctbb_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_pop,
    input wire logic        o_empty,
    input wire logic        o_found,
    input wire logic [12:0] o_box_top,
    input wire logic [12:0] o_box_left,
    input wire logic [12:0] o_box_bottom,
    input wire logic [12:0] o_box_right
);

    `CTBB_ASSERT_ALWAYS(a_empty_after_reset, i_clk, $past(!i_rst_n), o_empty, "result after reset")

    `CTBB_ASSERT_NOW(a_miss_box_origin, i_clk, i_rst_n, !o_empty && !o_found, o_box_top == 13'd0 && o_box_left == 13'd0 && o_box_bottom != 13'd0 && o_box_right != 13'd0, "bad no-hit box")

    `CTBB_ASSERT_NOW(a_hit_box_ordered, i_clk, i_rst_n, !o_empty && o_found, o_box_top <= o_box_bottom && o_box_left <= o_box_right, "box corners out of order")

    `CTBB_ASSERT_NEXT(a_result_held, i_clk, i_rst_n, !o_empty && !i_pop, !o_empty && $stable(o_found) && $stable(o_box_top) && $stable(o_box_right), "result changed while waiting")

endmodule

bind color_threshold_bounding_box_unit ctbb_checker u_ctbb_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_pop        (i_pop),
    .o_empty      (o_empty),
    .o_found      (o_found),
    .o_box_top    (o_box_top),
    .o_box_left   (o_box_left),
    .o_box_bottom (o_box_bottom),
    .o_box_right  (o_box_right)
);

`default_nettype wire

/* verif/color_threshold_bounding_box_unit_tb.sv */
// ---------------------------------------------------------------------------
// color_threshold_bounding_box_unit_tb
// Drives raster pixel beats through the colour-threshold bounding box unit
// and checks each frame result against an in-bench box predictor or a result
// written in the directed table, run first; then random phases with varied
// thresholds, frame sizes and back-pressure; oversize and zero dimensions last.
// ---------------------------------------------------------------------------
`default_nettype none

module color_threshold_bounding_box_unit_tb;
    import ctbb_pkg::*;

    // cycles with no beat on either side before the run is given up
    localparam int STALL_LIMIT = 2000;
    // pipeline depth plus margin: pixel to back end, back end to result
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_PHASES = 20;
    // pixels per closing phase; well short of a clamped row or column
    localparam int EDGE_PIXELS = 64;
    // index the unit does not decode; writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef enum logic {STEP_PIXEL, STEP_REG} t_step_kind;

    // one row of the directed table: a register write or a pixel beat,
    // the latter optionally carrying a hand-written frame result
    typedef struct packed {
        t_step_kind           kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_DIM_W-1:0] value;
        logic [CH_W-1:0]      blue;
        logic [CH_W-1:0]      green;
        logic [CH_W-1:0]      red;
        logic                 has_box;
        t_res                 box;
    } t_step;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_push;
    logic                 o_full;
    logic [CH_W-1:0]      i_chan_blue;
    logic [CH_W-1:0]      i_chan_green;
    logic [CH_W-1:0]      i_chan_red;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DIM_W-1:0] i_cfg_wdata;
    logic                 o_empty;
    logic                 i_pop = 1'b0;
    logic                 o_found;
    logic [OUT_W-1:0]     o_box_top;
    logic [OUT_W-1:0]     o_box_left;
    logic [OUT_W-1:0]     o_box_bottom;
    logic [OUT_W-1:0]     o_box_right;

    color_threshold_bounding_box_unit i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_push),
        .o_full       (o_full),
        .i_chan_blue  (i_chan_blue),
        .i_chan_green (i_chan_green),
        .i_chan_red   (i_chan_red),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_empty      (o_empty),
        .i_pop        (i_pop),
        .o_found      (o_found),
        .o_box_top    (o_box_top),
        .o_box_left   (o_box_left),
        .o_box_bottom (o_box_bottom),
        .o_box_right  (o_box_right)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // -----------------------------------------------------------------------
    // Box predictor: own copy of registers, raster position and running box
    // -----------------------------------------------------------------------
    logic [CH_W-1:0]      blue_lim, green_lim, red_lim;
    logic [CFG_DIM_W-1:0] width_reg, height_reg;
    logic [CNT_W-1:0]     col_cnt, row_cnt;
    logic [DIM_W-1:0]     min_row, min_col, max_row, max_col;
    logic                 any_hit;

    t_res box_queue [$];      // frame results still owed by the unit
    int   mismatch_count = 0;
    int   idle_pct = 0;       // chance per beat slot that the sender holds off
    int   stall_pct = 0;      // chance per cycle that the receiver holds off
    int   quiet_cycles = 0;

    // register value as the unit sees it: 0 means 1, oversize clamps
    function automatic logic [DIM_W-1:0] dim_in_use(input logic [CFG_DIM_W-1:0] v);
        if (v == '0)
            return DIM_W'(1);
        if (32'(v) > MAX_DIM)
            return DIM_W'(MAX_DIM);
        return DIM_W'(v);
    endfunction

    // empty box for a new frame, sized by the dimensions in force now
    function void reset_box();
        min_row = dim_in_use(height_reg);
        min_col = dim_in_use(width_reg);
        max_row = '0;
        max_col = '0;
        any_hit = 1'b0;
    endfunction

    // advance one pixel; returns 1 with the frame result on the last pixel
    function bit take_pixel(input logic [CH_W-1:0] b, g, r, output t_res res);
        logic [DIM_W-1:0] w, h;
        bit               last;
        w    = dim_in_use(width_reg);
        h    = dim_in_use(height_reg);
        last = 1'b0;
        res  = '0;
        if (b > blue_lim && g < green_lim && r < red_lim) begin
            // first hit of the frame loads every edge outright
            if (!any_hit || DIM_W'(row_cnt) < min_row) min_row = DIM_W'(row_cnt);
            if (!any_hit || DIM_W'(col_cnt) < min_col) min_col = DIM_W'(col_cnt);
            if (!any_hit || DIM_W'(row_cnt) > max_row) max_row = DIM_W'(row_cnt);
            if (!any_hit || DIM_W'(col_cnt) > max_col) max_col = DIM_W'(col_cnt);
            any_hit = 1'b1;
        end
        // >= so that a counter left past a shrunken size wraps next pixel
        if (32'(col_cnt) + 1 >= 32'(w)) begin
            col_cnt = '0;
            if (32'(row_cnt) + 1 >= 32'(h)) begin
                row_cnt = '0;
                last    = 1'b1;
            end else begin
                row_cnt = row_cnt + CNT_W'(1);
            end
        end else begin
            col_cnt = col_cnt + CNT_W'(1);
        end
        if (!last)
            return 1'b0;
        if (any_hit)
            res = '{1'b1, OUT_W'(min_row), OUT_W'(min_col), OUT_W'(max_row), OUT_W'(max_col)};
        else
            res = '{1'b0, '0, '0, OUT_W'(h), OUT_W'(w)};
        reset_box();
        return 1'b1;
    endfunction

    // -----------------------------------------------------------------------
    // Directed table helpers
    // -----------------------------------------------------------------------
    function automatic t_step pix(input logic [CH_W-1:0] b, g, r);
        t_step s;
        s       = '0;
        s.kind  = STEP_PIXEL;
        s.blue  = b;
        s.green = g;
        s.red   = r;
        return s;
    endfunction

    function automatic t_step pix_box(input logic [CH_W-1:0] b, g, r, input t_res bx);
        t_step s;
        s         = pix(b, g, r);
        s.has_box = 1'b1;
        s.box     = bx;
        return s;
    endfunction

    function automatic t_step reg_wr(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_DIM_W-1:0] v);
        t_step s;
        s       = '0;
        s.kind  = STEP_REG;
        s.idx   = idx;
        s.value = v;
        return s;
    endfunction

    // mostly random thresholds, the extremes now and then
    function automatic logic [CH_W-1:0] pick_level();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // small frames keep results frequent; zero stands for one
    function automatic logic [CFG_DIM_W-1:0] pick_dim();
        int r;
        r = $urandom_range(9);
        if (r == 9)
            return CFG_DIM_W'($urandom_range(24, 10));
        return CFG_DIM_W'(r);
    endfunction

    // -----------------------------------------------------------------------
    // Checking
    // -----------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    // result beat: compare with the oldest owed frame result
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && i_pop && !o_empty) begin
            if (box_queue.size() == 0) begin
                report_mismatch("result beat with no frame result owed");
            end else begin
                want = box_queue.pop_front();
                check_field("found", int'(o_found), int'(want.found));
                check_field("box_top", int'(o_box_top), int'(want.top));
                check_field("box_left", int'(o_box_left), int'(want.left));
                check_field("box_bottom", int'(o_box_bottom), int'(want.bottom));
                check_field("box_right", int'(o_box_right), int'(want.right));
            end
        end
    end

    // receiver: random hold-off at the rate of the current phase
    always @(posedge i_clk) begin
        i_pop <= i_rst_n && ($urandom_range(99) >= stall_pct);
    end

    // watchdog: any beat on either side restarts the count
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_push && !o_full) || (i_pop && !o_empty)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("[%0t] no beat for %0d cycles", $time, STALL_LIMIT);
            $display("color_threshold_bounding_box_unit_tb: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // -----------------------------------------------------------------------
    // Stimulus
    // -----------------------------------------------------------------------
    task automatic set_traffic(input int mode);
        case (mode)
            0:       begin idle_pct = 0;  stall_pct = 0;  end
            1:       begin idle_pct = 46; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 46; end
            default: begin idle_pct = 10; stall_pct = 10; end
        endcase
    endtask

    // one pixel beat; a hand-written result, if given, replaces the predicted one
    task automatic send_pixel(input logic [CH_W-1:0] b, g, r,
                              input logic has_box, input t_res bx);
        t_res res;
        bit   ends_frame;
        while ($urandom_range(99) < idle_pct) begin
            i_push <= 1'b0;
            @(posedge i_clk);
        end
        i_push       <= 1'b1;
        i_chan_blue  <= b;
        i_chan_green <= g;
        i_chan_red   <= r;
        do
            @(posedge i_clk);
        while (o_full);
        ends_frame = take_pixel(b, g, r, res);
        if (has_box)
            box_queue = {box_queue, bx};
        else if (ends_frame)
            box_queue = {box_queue, res};
    endtask

    // quiesce before register writes: all results out, pipeline flushed
    task automatic settle();
        i_push <= 1'b0;
        while (box_queue.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DIM_W-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_BLUE_MIN:     blue_lim   = v[CH_W-1:0];
            REG_GREEN_MAX:    green_lim  = v[CH_W-1:0];
            REG_RED_MAX:      red_lim    = v[CH_W-1:0];
            REG_FRAME_WIDTH:  width_reg  = v;
            REG_FRAME_HEIGHT: height_reg = v;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // new register setting, then n pixels; about half are built to qualify
    task automatic run_phase(input logic [CH_W-1:0] bl, gr, rd,
                             input logic [CFG_DIM_W-1:0] w, h, input int n);
        logic [CH_W-1:0] b, g, r;
        settle();
        write_reg(REG_BLUE_MIN, CFG_DIM_W'(bl));
        write_reg(REG_GREEN_MAX, CFG_DIM_W'(gr));
        write_reg(REG_RED_MAX, CFG_DIM_W'(rd));
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        repeat (n) begin
            b = 8'($urandom);
            g = 8'($urandom);
            r = 8'($urandom);
            if ($urandom_range(1) == 1) begin
                if (blue_lim != 8'hFF) b = 8'($urandom_range(255, int'(blue_lim) + 1));
                if (green_lim != 8'h00) g = 8'($urandom_range(int'(green_lim) - 1, 0));
                if (red_lim != 8'h00) r = 8'($urandom_range(int'(red_lim) - 1, 0));
            end
            send_pixel(b, g, r, 1'b0, '0);
        end
    endtask

    t_step dir_table [42];

    initial begin
        i_rst_n      <= 1'b0;
        i_push       <= 1'b0;
        i_chan_blue  <= '0;
        i_chan_green <= '0;
        i_chan_red   <= '0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= '0;
        i_cfg_wdata  <= '0;

        blue_lim   = RST_BLUE_MIN;
        green_lim  = RST_GREEN_MAX;
        red_lim    = RST_RED_MAX;
        width_reg  = RST_FRAME_WIDTH;
        height_reg = RST_FRAME_HEIGHT;
        col_cnt    = '0;
        row_cnt    = '0;
        reset_box();

        dir_table = '{
            // 2x2 frames, reset thresholds: each channel one step either side
            reg_wr(REG_FRAME_WIDTH, 13'd2),
            reg_wr(REG_FRAME_HEIGHT, 13'd2),
            pix(8'd206, 8'd189, 8'd149),
            pix(8'd205, 8'd0, 8'd0),
            pix(8'd255, 8'd190, 8'd0),
            pix_box(8'd255, 8'd0, 8'd150, t_res'{1'b1, 13'd0, 13'd0, 13'd0, 13'd0}),
            pix(8'd0, 8'd255, 8'd255),
            pix(8'd205, 8'd189, 8'd149),
            pix(8'd255, 8'd190, 8'd149),
            // nothing qualified: whole frame reported, found clear
            pix_box(8'd255, 8'd189, 8'd150, t_res'{1'b0, 13'd0, 13'd0, 13'd2, 13'd2}),
            // widest-open thresholds on a 3x2 frame
            reg_wr(REG_BLUE_MIN, 13'd0),
            reg_wr(REG_GREEN_MAX, 13'd255),
            reg_wr(REG_RED_MAX, 13'd255),
            reg_wr(REG_FRAME_WIDTH, 13'd3),
            pix(8'd0, 8'd0, 8'd0),
            pix(8'd1, 8'd254, 8'd254),
            pix(8'd255, 8'd255, 8'd0),
            pix(8'd255, 8'd0, 8'd255),
            pix(8'd128, 8'd0, 8'd0),
            pix_box(8'd0, 8'd0, 8'd0, t_res'{1'b1, 13'd0, 13'd1, 13'd1, 13'd1}),
            // closed thresholds, zero dimensions act as a 1x1 frame
            reg_wr(REG_BLUE_MIN, 13'd255),
            reg_wr(REG_GREEN_MAX, 13'd0),
            reg_wr(REG_RED_MAX, 13'd0),
            reg_wr(REG_FRAME_WIDTH, 13'd0),
            reg_wr(REG_FRAME_HEIGHT, 13'd0),
            reg_wr(REG_UNUSED, 13'h1FFF),
            pix_box(8'd255, 8'd255, 8'd255, t_res'{1'b0, 13'd0, 13'd0, 13'd1, 13'd1}),
            pix_box(8'd0, 8'd0, 8'd0, t_res'{1'b0, 13'd0, 13'd0, 13'd1, 13'd1}),
            // 4x3 frame shrunk to width 2 with the column counter at 3
            reg_wr(REG_BLUE_MIN, 13'd100),
            reg_wr(REG_GREEN_MAX, 13'd200),
            reg_wr(REG_RED_MAX, 13'd200),
            reg_wr(REG_FRAME_WIDTH, 13'd4),
            reg_wr(REG_FRAME_HEIGHT, 13'd3),
            pix(8'd0, 8'd0, 8'd0),
            pix(8'd100, 8'd0, 8'd0),
            pix(8'd101, 8'd199, 8'd199),
            reg_wr(REG_FRAME_WIDTH, 13'd2),
            pix(8'd200, 8'd0, 8'd0),
            pix(8'd0, 8'd0, 8'd0),
            pix(8'd255, 8'd0, 8'd0),
            pix(8'd0, 8'd0, 8'd0),
            pix(8'd255, 8'd0, 8'd0)
        };

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows, no back-pressure; writes only once the unit is quiet
        set_traffic(0);
        foreach (dir_table[k]) begin
            if (dir_table[k].kind == STEP_REG) begin
                if (k == 0 || dir_table[k-1].kind != STEP_REG)
                    settle();
                write_reg(dir_table[k].idx, dir_table[k].value);
            end else begin
                send_pixel(dir_table[k].blue, dir_table[k].green, dir_table[k].red,
                           dir_table[k].has_box, dir_table[k].box);
            end
        end

        // random phases; pixel counts are not chosen as frame multiples, so most
        // register changes land mid-frame
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            set_traffic(ph % 4);
            run_phase(pick_level(), pick_level(), pick_level(), pick_dim(), pick_dim(),
                      $urandom_range(65, 25));
        end

        // oversize and zero dimensions: clamped row, full-width row, clamped
        // column; the counters carry across each size change
        set_traffic(3);
        run_phase(8'hFF, 8'h00, 8'h00, 13'h1FFF, 13'd0, EDGE_PIXELS);
        set_traffic(0);
        run_phase(8'd128, 8'd128, 8'd128, 13'd4096, 13'd1, EDGE_PIXELS);
        set_traffic(2);
        run_phase(8'd128, 8'd128, 8'd128, 13'd0, 13'd5000, EDGE_PIXELS);

        i_push <= 1'b0;
        while (box_queue.size() != 0)
            @(posedge i_clk);
        // catch any stray result beat after the last owed one
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("color_threshold_bounding_box_unit_tb: PASS");
        end else begin
            $display("color_threshold_bounding_box_unit_tb: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* color_threshold_bounding_box_unit.f */
+incdir+src
src/ctbb_pkg.sv
src/ctbb_front.sv
src/ctbb_queue.sv
src/ctbb_back.sv
src/color_threshold_bounding_box_unit.sv
src/ctbb_checker.sv
verif/color_threshold_bounding_box_unit_tb.sv
